// ----- design/iobkc_pkg.sv -----
// Shared types, codes and constants of the I/O board keyboard/clock register block.
package iobkc_pkg;

    // Event kinds carried by an input word
    localparam logic [2:0] KIND_BUS_READ   = 3'd0;
    localparam logic [2:0] KIND_BUS_WRITE  = 3'd1;
    localparam logic [2:0] KIND_DISP_READ  = 3'd2;
    localparam logic [2:0] KIND_DISP_WRITE = 3'd3;
    localparam logic [2:0] KIND_TICK       = 3'd4;
    localparam logic [2:0] KIND_CLOCK      = 3'd5;
    localparam logic [2:0] KIND_KEY        = 3'd6;

    // Decoded bus byte offsets (octal)
    localparam logic [7:0] OFS_KBD_LOW   = 8'o100;
    localparam logic [7:0] OFS_KBD_HIGH  = 8'o102;
    localparam logic [7:0] OFS_BEEP      = 8'o110;
    localparam logic [7:0] OFS_KBD_CSR   = 8'o112;
    localparam logic [7:0] OFS_USEC_LOW  = 8'o120;
    localparam logic [7:0] OFS_USEC_HIGH = 8'o122;

    // Configuration register indexes
    localparam logic CFG_IDX_USEC  = 1'b0;
    localparam logic CFG_IDX_FRAME = 1'b1;

    // Configuration reset values
    localparam logic [7:0]  CFG_USEC_RESET  = 8'd5;
    localparam logic [23:0] CFG_FRAME_RESET = 24'd80000;

    // Status bit positions
    localparam int KBD_READY_BIT = 5;
    localparam int CLK_READY_BIT = 6;
    localparam int DISP_FLAG_BIT = 4;
    localparam int DISP_INV_BIT  = 2;

    typedef struct packed {
        logic [7:0]  cycles_per_microsecond;
        logic [23:0] cycles_per_frame;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  offset;
        logic [31:0] write_data;
        logic [31:0] key_code;
    } t_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        beep;
        logic        unibus_interrupt;
        logic        display_interrupt;
        logic        inverse_video;
        logic        inverse_video_changed;
    } t_result;

endpackage

// ----- design/iobkc_core.sv -----
// Register state and single-pass event decode of the I/O board keyboard/clock block.
module iobkc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iobkc_pkg::t_cfg   i_cfg,
    input  logic              i_step,
    input  iobkc_pkg::t_item  i_item,
    output iobkc_pkg::t_result o_result
);

    logic [31:0] r_key_scan,  n_key_scan;
    logic [6:0]  r_kbd_stat,  n_kbd_stat;
    logic [31:0] r_usec,      n_usec;
    logic [7:0]  r_prescale,  n_prescale;
    logic [31:0] r_usec_latch, n_usec_latch;
    logic [23:0] r_frame,     n_frame;
    logic [31:0] r_disp,      n_disp;

    logic [7:0]  prescale_inc;
    logic [23:0] frame_inc;

    assign prescale_inc = r_prescale + 8'd1;
    assign frame_inc    = r_frame + 24'd1;

    // Decode one word: next state and its result
    always_comb begin
        n_key_scan   = r_key_scan;
        n_kbd_stat   = r_kbd_stat;
        n_usec       = r_usec;
        n_prescale   = r_prescale;
        n_usec_latch = r_usec_latch;
        n_frame      = r_frame;
        n_disp       = r_disp;
        o_result     = '0;
        case (i_item.kind)
            iobkc_pkg::KIND_BUS_READ: begin
                case (i_item.offset)
                    iobkc_pkg::OFS_KBD_LOW: begin
                        o_result.read_data = {16'd0, r_key_scan[15:0]};
                        n_kbd_stat[iobkc_pkg::KBD_READY_BIT] = 1'b0;
                    end
                    iobkc_pkg::OFS_KBD_HIGH: begin
                        o_result.read_data = {16'd0, r_key_scan[31:16]};
                        n_kbd_stat[iobkc_pkg::KBD_READY_BIT] = 1'b0;
                    end
                    iobkc_pkg::OFS_BEEP: begin
                        o_result.beep = 1'b1;
                    end
                    iobkc_pkg::OFS_KBD_CSR: begin
                        o_result.read_data = {25'd0, r_kbd_stat};
                    end
                    iobkc_pkg::OFS_USEC_LOW: begin
                        n_usec_latch       = r_usec;
                        o_result.read_data = {16'd0, r_usec[15:0]};
                    end
                    iobkc_pkg::OFS_USEC_HIGH: begin
                        o_result.read_data = {16'd0, r_usec_latch[31:16]};
                    end
                    default: begin
                    end
                endcase
            end
            iobkc_pkg::KIND_BUS_WRITE: begin
                if (i_item.offset == iobkc_pkg::OFS_KBD_CSR) begin
                    n_kbd_stat = {r_kbd_stat[6:4], i_item.write_data[3:0]};
                end
            end
            iobkc_pkg::KIND_DISP_READ: begin
                o_result.read_data = r_disp;
            end
            iobkc_pkg::KIND_DISP_WRITE: begin
                o_result.inverse_video_changed =
                    r_disp[iobkc_pkg::DISP_INV_BIT] ^ i_item.write_data[iobkc_pkg::DISP_INV_BIT];
                n_disp = i_item.write_data;
                n_disp[iobkc_pkg::DISP_FLAG_BIT] = 1'b0;
            end
            iobkc_pkg::KIND_TICK: begin
                // advance prescaler; zero or lowered limit fires at once
                if (prescale_inc >= i_cfg.cycles_per_microsecond || prescale_inc == 8'd0) begin
                    n_prescale = 8'd0;
                    n_usec     = r_usec + 32'd1;
                end else begin
                    n_prescale = prescale_inc;
                end
                // advance frame divider
                if (frame_inc >= i_cfg.cycles_per_frame || frame_inc == 24'd0) begin
                    n_frame = 24'd0;
                    n_disp[iobkc_pkg::DISP_FLAG_BIT] = 1'b1;
                end else begin
                    n_frame = frame_inc;
                end
            end
            iobkc_pkg::KIND_CLOCK: begin
                n_kbd_stat[iobkc_pkg::CLK_READY_BIT] = 1'b1;
                o_result.unibus_interrupt = 1'b1;
            end
            iobkc_pkg::KIND_KEY: begin
                n_key_scan = i_item.key_code;
                n_kbd_stat[iobkc_pkg::KBD_READY_BIT] = 1'b1;
            end
            default: begin
            end
        endcase
        o_result.display_interrupt = n_disp[iobkc_pkg::DISP_FLAG_BIT];
        o_result.inverse_video     = n_disp[iobkc_pkg::DISP_INV_BIT];
    end

    // Commit state when the word leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_scan   <= '0;
            r_kbd_stat   <= '0;
            r_usec       <= '0;
            r_prescale   <= '0;
            r_usec_latch <= '0;
            r_frame      <= '0;
            r_disp       <= '0;
        end else if (i_step) begin
            r_key_scan   <= n_key_scan;
            r_kbd_stat   <= n_kbd_stat;
            r_usec       <= n_usec;
            r_prescale   <= n_prescale;
            r_usec_latch <= n_usec_latch;
            r_frame      <= n_frame;
            r_disp       <= n_disp;
        end
    end

    a_clock_sets_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.kind == iobkc_pkg::KIND_CLOCK |=> r_kbd_stat[iobkc_pkg::CLK_READY_BIT])
        else $error("clock event did not set clock ready bit");

    a_disp_write_clears_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.kind == iobkc_pkg::KIND_DISP_WRITE
        |=> !r_disp[iobkc_pkg::DISP_FLAG_BIT])
        else $error("display write left interrupt flag set");

    a_key_stores_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.kind == iobkc_pkg::KIND_KEY
        |=> r_key_scan == $past(i_item.key_code) && r_kbd_stat[iobkc_pkg::KBD_READY_BIT])
        else $error("key event not stored");

    a_idle_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_usec) && $stable(r_disp))
        else $error("state moved without a word");

endmodule

// ----- design/io_board_keyboard_clock_regs_top.sv -----
// Top level of the I/O board keyboard/clock register block: handshake stages and config.
//
// Input channel (i_valid / o_ready) carries one event word: kind, offset, write data
// and key code. Output channel (o_valid / i_ready) returns exactly one result word per
// input word, in order: read data, beep, unibus interrupt pulse, display interrupt
// level, inverse video level and inverse video change.
// An accepted word sits in the input register; when it advances it is decoded, the
// board state is updated and the result register is loaded. One word is taken every
// cycle while the receiver does not stall.
// The configuration port (i_cfg_we, i_cfg_index, i_cfg_wdata) writes the microsecond
// prescale limit (index 0) or the frame divider limit (index 1); write it
// only while no word is in flight.
// Reset clears all board state and both handshake stages and restores the limits to 5
// and 80000. When the receiver stalls, the result register holds; the input register
// still takes one more word, then o_ready drops until the result drains.
module io_board_keyboard_clock_regs_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event words
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_offset,
    input  logic [31:0] i_write_data,
    input  logic [31:0] i_key_code,
    // result words
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_read_data,
    output logic        o_beep,
    output logic        o_unibus_interrupt,
    output logic        o_display_interrupt,
    output logic        o_inverse_video,
    output logic        o_inverse_video_changed,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_wdata
);

    iobkc_pkg::t_cfg    r_cfg;
    iobkc_pkg::t_item   r_in;
    logic               r_in_valid;
    iobkc_pkg::t_result r_out;
    logic               r_out_valid;
    iobkc_pkg::t_result result;
    logic               advance;
    logic               in_accept;

    assign advance   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || advance;
    assign in_accept = i_valid && o_ready;

    // Write configuration limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cycles_per_microsecond <= iobkc_pkg::CFG_USEC_RESET;
            r_cfg.cycles_per_frame       <= iobkc_pkg::CFG_FRAME_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                iobkc_pkg::CFG_IDX_USEC:  r_cfg.cycles_per_microsecond <= i_cfg_wdata[7:0];
                iobkc_pkg::CFG_IDX_FRAME: r_cfg.cycles_per_frame       <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Hold the input word until it can advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.kind       <= i_kind;
            r_in.offset     <= i_offset;
            r_in.write_data <= i_write_data;
            r_in.key_code   <= i_key_code;
        end
    end

    iobkc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_step   (advance),
        .i_item   (r_in),
        .o_result (result)
    );

    // Load the result word; drop valid when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_valid                 = r_out_valid;
    assign o_read_data             = r_out.read_data;
    assign o_beep                  = r_out.beep;
    assign o_unibus_interrupt      = r_out.unibus_interrupt;
    assign o_display_interrupt     = r_out.display_interrupt;
    assign o_inverse_video         = r_out.inverse_video;
    assign o_inverse_video_changed = r_out.inverse_video_changed;

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_in_valid)
        else $error("accepted word lost from input stage");

    a_advance_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("decoded word produced no result");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_ready |-> !o_ready)
        else $error("input taken while both stages are full");

endmodule
